### sv/dvs_pkg.sv
// Package for the frame-to-event emulator: payload structs, queue job,
// state enums and fixed field widths. No dependencies.
`default_nettype none

package dvs_pkg;

    localparam int X_W     = 10;
    localparam int Y_W     = 9;
    localparam int VAL_W   = 16;
    localparam int TIME_W  = 48;
    localparam int LVL_W   = 24;
    localparam int CNT_W   = 7;
    localparam int CFG_W   = 24;
    localparam int CIDX_W  = 2;
    localparam int PROD_W  = 72;

    // Register indexes of the configuration port.
    localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_ON_THRESH    = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_OFF_THRESH   = 2'd3;

    typedef struct packed {
        logic [X_W-1:0]    pixel_x;
        logic [Y_W-1:0]    pixel_y;
        logic [VAL_W-1:0]  pixel_value;
        logic [TIME_W-1:0] frame_time;
    } t_pixel;

    typedef struct packed {
        logic [X_W-1:0]    event_x;
        logic [Y_W-1:0]    event_y;
        logic [TIME_W-1:0] event_time;
        logic              polarity;
        logic              last_of_pixel;
        logic              overflow;
    } t_event;

    // One pixel's worth of event work, passed from front to back.
    typedef struct packed {
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic              on;
        logic [LVL_W-1:0]  thr;
        logic [LVL_W-1:0]  mag;
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] dt;
        logic [CNT_W-1:0]  emit;
        logic              overflow;
    } t_job;

    typedef struct packed {
        logic clearing;
        logic busy;
    } t_front_status;

    typedef struct packed {
        logic [LVL_W-1:0] frame_width_thr_unused;
    } t_unused_dummy;

    typedef struct packed {
        logic              mark;
        logic [LVL_W-1:0]  level;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    typedef enum logic [2:0] {
        F_CLEAR, F_IDLE, F_ADDR, F_CLASS, F_DIV, F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE, B_MUL_LO, B_MUL_HI, B_SUM, B_DIV, B_EMIT
    } t_back_state;

endpackage

`default_nettype wire

### sv/dvs_event_from_frames.sv
// Event camera emulator top level: configuration registers, front, queue
// and back. Depends on dvs_pkg, dvs_front, dvs_queue and dvs_back.
//
// After reset the block clears the valid marks of its reference memory,
// one entry per cycle, over all MAX_WIDTH*MAX_HEIGHT entries (307200 by
// default); pixels are not taken meanwhile, configuration writes are. A
// pixel outside the frame goes back to idle after the address check; one
// that only primes or stays below threshold also passes classification;
// one that crosses then waits on the 24-step crossing-count divider and
// for room in the queue. Its events are produced by the back while the
// front takes further pixels: set-up forms two partial products, starts
// the divider and runs a 72-step divider, then emits one event per cycle
// while the receiver is ready. Jobs queue two deep between front and back.
`default_nettype none

module dvs_event_from_frames import dvs_pkg::*; #(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480,
    parameter int MAX_EVENTS = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_pix_valid,
    output logic                   o_pix_ready,
    input  wire t_pixel            i_pixel,
    output logic                   o_evt_valid,
    input  wire logic              i_evt_ready,
    output t_event                 o_event,
    input  wire logic              i_cfg_we,
    input  wire logic [CIDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    logic [X_W-1:0]   r_frame_width;
    logic [Y_W-1:0]   r_frame_height;
    logic [LVL_W-1:0] r_on_thr;
    logic [LVL_W-1:0] r_off_thr;

    logic          q_push;
    logic          q_pop;
    logic          q_not_full;
    logic          q_not_empty;
    t_job          q_in;
    t_job          q_out;
    t_front_status front_status;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= X_W'(640);
            r_frame_height <= Y_W'(480);
            r_on_thr       <= LVL_W'(2560);
            r_off_thr      <= LVL_W'(2560);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[X_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[Y_W-1:0];
                CFG_ON_THRESH:    r_on_thr       <= i_cfg_data[LVL_W-1:0];
                CFG_OFF_THRESH:   r_off_thr      <= i_cfg_data[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    dvs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_EVENTS (MAX_EVENTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pix_valid    (i_pix_valid),
        .o_pix_ready    (o_pix_ready),
        .i_pixel        (i_pixel),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_on_thr       (r_on_thr),
        .i_off_thr      (r_off_thr),
        .o_push         (q_push),
        .o_job          (q_in),
        .i_not_full     (q_not_full),
        .o_status       (front_status)
    );

    dvs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_job       (q_in),
        .o_not_full  (q_not_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_job       (q_out)
    );

    dvs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_not_empty (q_not_empty),
        .i_job       (q_out),
        .o_pop       (q_pop),
        .o_evt_valid (o_evt_valid),
        .i_evt_ready (i_evt_ready),
        .o_event     (o_event)
    );

    // No pixel is taken while the memory sweep runs.
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_status.clearing |-> !o_pix_ready)
        else $error("pixel ready during memory clearing");

    // The queue is never written when full nor read when empty.
    a_queue_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && !q_not_full) && !(q_pop && !q_not_empty))
        else $error("queue overrun or underrun");

    // Events of one pixel follow without a gap once one is taken.
    a_events_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt_valid && i_evt_ready && !o_event.last_of_pixel) |=> o_evt_valid)
        else $error("gap inside one pixel's events");

    // Event times of one pixel do not go backwards.
    a_time_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt_valid && i_evt_ready && !o_event.last_of_pixel)
        |=> (o_event.event_time >= $past(o_event.event_time)))
        else $error("event time decreased within a pixel");

endmodule

`default_nettype wire

### sv/dvs_div.sv
// Restoring divider, one quotient bit per cycle, 24-bit divisor.
// Depends on dvs_pkg for the divisor width.
`default_nettype none

module dvs_div import dvs_pkg::*; #(
    parameter int NUM_W = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [LVL_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quo,
    output logic [LVL_W-1:0]      o_rem
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [LVL_W-1:0] r_rem;
    logic [LVL_W-1:0] r_den;
    logic [LVL_W:0]   trial;
    logic             fits;

    // Bring down the next numerator bit and try the subtraction.
    assign trial = {r_rem, r_num[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient shifts in where the numerator shifts out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], fits};
            r_rem <= fits ? LVL_W'(trial - {1'b0, r_den}) : trial[LVL_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

### sv/dvs_queue.sv
// Two-entry queue of event jobs between the front and the back.
// Depends on dvs_pkg for t_job.
`default_nettype none

module dvs_queue import dvs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_not_full,
    input  wire logic i_pop,
    output logic      o_not_empty,
    output t_job      o_job
);

    t_job       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    assign o_not_full  = r_cnt != 2'd2;
    assign o_not_empty = r_cnt != 2'd0;
    assign o_job       = r_slot[r_rp];

endmodule

`default_nettype wire

### sv/dvs_front.sv
// Front part: accepts pixels, holds the per-pixel reference memory, counts
// crossings and queues event jobs. Depends on dvs_pkg and dvs_div.
`default_nettype none

module dvs_front import dvs_pkg::*; #(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480,
    parameter int MAX_EVENTS = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_pix_valid,
    output logic                  o_pix_ready,
    input  wire t_pixel           i_pixel,
    input  wire logic [X_W-1:0]   i_frame_width,
    input  wire logic [Y_W-1:0]   i_frame_height,
    input  wire logic [LVL_W-1:0] i_on_thr,
    input  wire logic [LVL_W-1:0] i_off_thr,
    output logic                  o_push,
    output t_job                  o_job,
    input  wire logic             i_not_full,
    output t_front_status         o_status
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = 25;

    t_front_state     r_state, n_state;
    t_pixel           r_pix, n_pix;
    logic [AW-1:0]    r_addr, n_addr;
    logic [AW-1:0]    r_clr, n_clr;
    logic             r_on, n_on;
    logic [LVL_W-1:0] r_mag, n_mag;
    logic [LVL_W-1:0] r_thr, n_thr;
    logic [LVL_W-1:0] r_level, n_level;
    logic [TIME_W-1:0] r_stamp, n_stamp;
    t_job             r_job, n_job;

    t_entry           r_mem [DEPTH];
    t_entry           r_rdata;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    t_entry           mem_wdata;
    logic             mem_re;

    logic [X_W+Y_W-1:0] row_base;
    logic [IW-1:0]      idx_full;
    logic               in_range;
    logic [LVL_W-1:0]   sample;
    logic               cls_on;
    logic [LVL_W-1:0]   cls_mag;
    logic [LVL_W-1:0]   cls_thr;
    logic               div_start;
    logic               div_done;
    logic [LVL_W-1:0]   div_quo;
    logic [LVL_W-1:0]   div_rem;
    logic [LVL_W-1:0]   step;

    // Pixel index and frame bounds.
    assign row_base = (X_W+Y_W)'(r_pix.pixel_y) * (X_W+Y_W)'(i_frame_width);
    assign idx_full = IW'(row_base) + IW'(r_pix.pixel_x);
    assign in_range = (r_pix.pixel_x < i_frame_width) && (r_pix.pixel_y < i_frame_height)
                   && (idx_full < IW'(DEPTH));

    // Classification of the stored reference against the new sample.
    assign sample  = {r_pix.pixel_value, 8'h00};
    assign cls_on  = sample >= r_rdata.level;
    assign cls_mag = cls_on ? sample - r_rdata.level : r_rdata.level - sample;
    always_comb begin
        cls_thr = cls_on ? i_on_thr : i_off_thr;
        if (cls_thr == '0) begin
            cls_thr = LVL_W'(1);
        end
    end

    // Crossing count: mag / thr.
    dvs_div #(.NUM_W(LVL_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (cls_mag),
        .i_den   (cls_thr),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // Count times threshold equals magnitude less the remainder.
    assign step = r_mag - div_rem;

    // Reference memory, registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[n_addr];
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pix   <= n_pix;
        r_addr  <= n_addr;
        r_on    <= n_on;
        r_mag   <= n_mag;
        r_thr   <= n_thr;
        r_level <= n_level;
        r_stamp <= n_stamp;
        r_job   <= n_job;
    end

    // Next state and outputs.
    always_comb begin
        n_state   = r_state;
        n_pix     = r_pix;
        n_addr    = r_addr;
        n_clr     = r_clr;
        n_on      = r_on;
        n_mag     = r_mag;
        n_thr     = r_thr;
        n_level   = r_level;
        n_stamp   = r_stamp;
        n_job     = r_job;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        mem_re    = 1'b0;
        div_start = 1'b0;
        o_pix_ready = 1'b0;
        o_push    = 1'b0;
        case (r_state)
            F_CLEAR: begin
                // Sweep the memory once, clearing every valid mark.
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = F_IDLE;
                end
            end
            F_IDLE: begin
                o_pix_ready = 1'b1;
                if (i_pix_valid) begin
                    n_pix   = i_pixel;
                    n_state = F_ADDR;
                end
            end
            F_ADDR: begin
                n_addr = idx_full[AW-1:0];
                if (in_range) begin
                    mem_re  = 1'b1;
                    n_state = F_CLASS;
                end else begin
                    n_state = F_IDLE;
                end
            end
            F_CLASS: begin
                n_on    = cls_on;
                n_mag   = cls_mag;
                n_thr   = cls_thr;
                n_level = r_rdata.level;
                n_stamp = r_rdata.stamp;
                if (!r_rdata.mark) begin
                    // First sample of this pixel primes the reference only.
                    mem_we    = 1'b1;
                    mem_wdata = '{mark: 1'b1, level: sample, stamp: r_pix.frame_time};
                    n_state   = F_IDLE;
                end else if (cls_mag < cls_thr) begin
                    n_state = F_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = F_DIV;
                end
            end
            F_DIV: begin
                if (div_done) begin
                    mem_we    = 1'b1;
                    mem_wdata = '{mark: 1'b1,
                                  level: r_on ? r_level + step : r_level - step,
                                  stamp: r_pix.frame_time};
                    n_job.x        = r_pix.pixel_x;
                    n_job.y        = r_pix.pixel_y;
                    n_job.on       = r_on;
                    n_job.thr      = r_thr;
                    n_job.mag      = r_mag;
                    n_job.stamp    = r_stamp;
                    n_job.dt       = (r_pix.frame_time >= r_stamp)
                                   ? r_pix.frame_time - r_stamp : '0;
                    n_job.overflow = div_quo > LVL_W'(MAX_EVENTS);
                    n_job.emit     = n_job.overflow ? CNT_W'(MAX_EVENTS)
                                                    : div_quo[CNT_W-1:0];
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (i_not_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    assign o_job             = r_job;
    assign o_status.clearing = r_state == F_CLEAR;
    assign o_status.busy     = r_state != F_IDLE;

endmodule

`default_nettype wire

### sv/dvs_back.sv
// Back part: turns one queued job into its events with interpolated times
// and drives the output register. Depends on dvs_pkg and dvs_div.
`default_nettype none

module dvs_back import dvs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_not_empty,
    input  wire t_job i_job,
    output logic      o_pop,
    output logic      o_evt_valid,
    input  wire logic i_evt_ready,
    output t_event    o_event
);

    t_back_state        r_state, n_state;
    t_job               r_job;
    logic [2*LVL_W-1:0] r_plo;
    logic [2*LVL_W-1:0] r_phi;
    logic [TIME_W-1:0]  r_qs;
    logic [LVL_W-1:0]   r_rs;
    logic [TIME_W-1:0]  r_t;
    logic [LVL_W-1:0]   r_r;
    logic [CNT_W-1:0]   r_i;
    logic               r_ovalid;
    t_event             r_out;

    logic               div_start;
    logic               div_done;
    logic [PROD_W-1:0]  div_quo;
    logic [LVL_W-1:0]   div_rem;
    logic [PROD_W-1:0]  prod;
    logic               load;
    logic [LVL_W:0]     r_sum;
    logic               wrap;
    logic [TIME_W-1:0]  t_next;
    logic [LVL_W-1:0]   r_next;

    // thr*dt assembled from two registered 24x24 partial products.
    assign prod = {r_phi, {LVL_W{1'b0}}} + PROD_W'(r_plo);

    // thr*dt / mag gives the per-event time step as quotient and remainder.
    dvs_div #(.NUM_W(PROD_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (prod),
        .i_den   (r_job.mag),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // Running floor((i+1)*thr*dt/mag): add the step, carry the remainder.
    assign r_sum  = {1'b0, r_r} + {1'b0, r_rs};
    assign wrap   = r_sum >= {1'b0, r_job.mag};
    assign r_next = wrap ? LVL_W'(r_sum - {1'b0, r_job.mag}) : r_sum[LVL_W-1:0];
    assign t_next = r_t + r_qs + TIME_W'(wrap);

    // Output register takes a new event when empty or being drained.
    assign load = (r_state == B_EMIT) && (!r_ovalid || i_evt_ready);

    // State and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_evt_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == B_MUL_LO) begin
            r_plo <= r_job.thr * r_job.dt[LVL_W-1:0];
        end
        if (r_state == B_MUL_HI) begin
            r_phi <= r_job.thr * r_job.dt[TIME_W-1:LVL_W];
        end
        if (r_state == B_DIV && div_done) begin
            r_qs <= div_quo[TIME_W-1:0];
            r_rs <= div_rem;
            r_t  <= '0;
            r_r  <= '0;
            r_i  <= '0;
        end
        if (load) begin
            r_t <= t_next;
            r_r <= r_next;
            r_i <= r_i + 1'b1;
            r_out.event_x       <= r_job.x;
            r_out.event_y       <= r_job.y;
            r_out.event_time    <= r_job.stamp + t_next;
            r_out.polarity      <= r_job.on;
            r_out.last_of_pixel <= (r_i + 1'b1) == r_job.emit;
            r_out.overflow      <= r_job.overflow;
        end
    end

    // Next state.
    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        div_start = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_not_empty) begin
                    o_pop   = 1'b1;
                    n_state = B_MUL_LO;
                end
            end
            B_MUL_LO: n_state = B_MUL_HI;
            B_MUL_HI: n_state = B_SUM;
            B_SUM: begin
                div_start = 1'b1;
                n_state   = B_DIV;
            end
            B_DIV: begin
                if (div_done) begin
                    n_state = B_EMIT;
                end
            end
            B_EMIT: begin
                if (load && (r_i + 1'b1) == r_job.emit) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    assign o_evt_valid = r_ovalid;
    assign o_event     = r_out;

endmodule

`default_nettype wire

### sim/tb_dvs_event_from_frames.sv
// Self-checking testbench for dvs_event_from_frames: directed pixels, then random phases
// under several register settings and handshake patterns. Depends on dvs_pkg and the RTL.
`default_nettype none

module tb_dvs_event_from_frames;
    import dvs_pkg::*;

    localparam int          PIXELS      = 640 * 480;
    localparam int          EVENT_CAP   = 64;
    localparam int          CYCLE_LIMIT = 2500000;
    localparam int          SETTLE      = 200;
    localparam bit [47:0]   TIME_TOP    = 48'hFFFF_FFFF_FFFF;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_pix_valid;
    logic              o_pix_ready;
    t_pixel            i_pixel;
    logic              o_evt_valid;
    logic              i_evt_ready;
    t_event            o_event;
    logic              i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;

    dvs_event_from_frames u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix_valid),
        .o_pix_ready (o_pix_ready),
        .i_pixel     (i_pixel),
        .o_evt_valid (o_evt_valid),
        .i_evt_ready (i_evt_ready),
        .o_event     (o_event),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the registers and of the per-pixel reference memory.
    bit [X_W-1:0]    width_reg;
    bit [Y_W-1:0]    height_reg;
    bit [LVL_W-1:0]  on_thr_reg;
    bit [LVL_W-1:0]  off_thr_reg;
    bit              primed_mem [int];
    bit [LVL_W-1:0]  level_mem [int];
    bit [TIME_W-1:0] stamp_mem [int];

    t_event          new_events [$];
    t_event          expected_events [$];
    int              mismatches;
    int              sender_idle_pct;
    int              receiver_stall_pct;
    int              holdoff_cycles;
    int              cycle_count;
    bit [TIME_W-1:0] time_now;
    int              cluster_w;
    int              cluster_h;

    // One directed row: a pixel and, where obvious, the events it must give.
    typedef struct {
        t_pixel          pix;
        bit              typed;
        int              n_events;
        bit [TIME_W-1:0] t0;
        bit [TIME_W-1:0] t1;
        bit              pol;
    } t_row;

    t_row directed_rows [13] = '{
        '{'{10'd0, 9'd0, 16'd100, 48'd1000}, 1'b1, 0, 48'd0, 48'd0, 1'b0},
        '{'{10'd0, 9'd0, 16'd110, 48'd2000}, 1'b1, 1, 48'd2000, 48'd0, 1'b1},
        '{'{10'd0, 9'd0, 16'd90, 48'd3000}, 1'b1, 2, 48'd2500, 48'd3000, 1'b0},
        '{'{10'd0, 9'd0, 16'd90, 48'd4000}, 1'b1, 0, 48'd0, 48'd0, 1'b0},
        '{'{10'd639, 9'd479, 16'd0, 48'd5}, 1'b1, 0, 48'd0, 48'd0, 1'b0},
        '{'{10'd639, 9'd479, 16'hFFFF, 48'd10}, 1'b0, 0, 48'd0, 48'd0, 1'b0},
        '{'{10'd639, 9'd479, 16'd0, 48'd3}, 1'b0, 0, 48'd0, 48'd0, 1'b0},
        '{'{10'd640, 9'd0, 16'd5, 48'd0}, 1'b1, 0, 48'd0, 48'd0, 1'b0},
        '{'{10'd0, 9'd480, 16'd5, 48'd0}, 1'b1, 0, 48'd0, 48'd0, 1'b0},
        '{'{10'h3FF, 9'h1FF, 16'hFFFF, TIME_TOP}, 1'b1, 0, 48'd0, 48'd0, 1'b0},
        '{'{10'd1, 9'd0, 16'hFFFF, TIME_TOP - 48'd15}, 1'b1, 0, 48'd0, 48'd0, 1'b0},
        '{'{10'd1, 9'd0, 16'd0, TIME_TOP}, 1'b0, 0, 48'd0, 48'd0, 1'b0},
        '{'{10'd2, 9'd0, 16'd0, 48'd0}, 1'b1, 0, 48'd0, 48'd0, 1'b0}
    };

    // Works out the events of one accepted pixel and updates the shadow state.
    task automatic predict_pixel(input t_pixel p);
        int unsigned     idx;
        bit [LVL_W-1:0]  sample;
        bit [LVL_W-1:0]  ref_lvl;
        bit [LVL_W-1:0]  mag;
        bit [LVL_W-1:0]  thr;
        bit              on;
        int unsigned     count;
        int unsigned     emit;
        bit [TIME_W-1:0] dt;
        bit [127:0]      frac;
        t_event          ev;
        new_events.delete();
        if (p.pixel_x >= width_reg || p.pixel_y >= height_reg) return;
        idx = int'(p.pixel_y) * int'(width_reg) + int'(p.pixel_x);
        if (idx >= PIXELS) return;
        sample = {p.pixel_value, 8'h00};
        if (!primed_mem.exists(idx)) begin
            primed_mem[idx] = 1'b1;
            level_mem[idx]  = sample;
            stamp_mem[idx]  = p.frame_time;
            return;
        end
        ref_lvl = level_mem[idx];
        on      = (sample >= ref_lvl);
        mag     = on ? sample - ref_lvl : ref_lvl - sample;
        thr     = on ? on_thr_reg : off_thr_reg;
        if (thr == '0) thr = LVL_W'(1);
        if (mag < thr) return;
        count = 32'(mag / thr);
        emit  = (count > EVENT_CAP) ? EVENT_CAP : count;
        dt    = (p.frame_time >= stamp_mem[idx]) ? p.frame_time - stamp_mem[idx] : '0;
        for (int unsigned i = 0; i < emit; i++) begin
            frac = (128'(i + 1) * 128'(thr) * 128'(dt)) / 128'(mag);
            ev.event_x       = p.pixel_x;
            ev.event_y       = p.pixel_y;
            ev.event_time    = stamp_mem[idx] + frac[TIME_W-1:0];
            ev.polarity      = on;
            ev.last_of_pixel = (i + 1 == emit);
            ev.overflow      = (count > EVENT_CAP);
            new_events.insert(new_events.size(), ev);
        end
        level_mem[idx] = on ? ref_lvl + LVL_W'(count * thr) : ref_lvl - LVL_W'(count * thr);
        stamp_mem[idx] = p.frame_time;
    endtask

    function automatic bit in_frame(input t_pixel p);
        return p.pixel_x < width_reg && p.pixel_y < height_reg
            && int'(p.pixel_y) * int'(width_reg) + int'(p.pixel_x) < PIXELS;
    endfunction

    // Writes one register at a falling edge and mirrors it in the shadow copy.
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_FRAME_WIDTH:  width_reg   = val[X_W-1:0];
            CFG_FRAME_HEIGHT: height_reg  = val[Y_W-1:0];
            CFG_ON_THRESH:    on_thr_reg  = val;
            CFG_OFF_THRESH:   off_thr_reg = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offers one pixel, holding it until accepted; expected events are queued on acceptance.
    task automatic send_pixel(input t_pixel p, input bit typed, input t_event typed_evs[$]);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_pix_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_pix_valid <= 1'b1;
        i_pixel     <= p;
        forever begin
            #1;
            if (o_pix_ready) break;
            @(negedge i_clk);
        end
        @(posedge i_clk);
        predict_pixel(p);
        if (typed) new_events = typed_evs;
        foreach (new_events[k]) expected_events.insert(expected_events.size(), new_events[k]);
    endtask

    // Waits until every expected event has come and the front has drained.
    task automatic settle_block();
        @(negedge i_clk);
        i_pix_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_pixel random_pixel();
        t_pixel p;
        if ($urandom_range(99) < 8) begin
            p.pixel_x = X_W'($urandom_range(0, 1023));
            p.pixel_y = Y_W'($urandom_range(0, 511));
        end else begin
            p.pixel_x = X_W'($urandom_range(0, cluster_w - 1));
            p.pixel_y = Y_W'($urandom_range(0, cluster_h - 1));
        end
        p.pixel_value = ($urandom_range(0, 2) == 0) ? VAL_W'($urandom_range(0, 65535))
                                                    : VAL_W'($urandom_range(0, 255));
        if ($urandom_range(99) < 4) begin
            p.frame_time = time_now - TIME_W'($urandom_range(0, 500));
        end else begin
            time_now     = time_now + TIME_W'($urandom_range(0, 2000));
            p.frame_time = time_now;
        end
        return p;
    endfunction

    // Random phase: sends pixels until the given number have landed inside the frame.
    task automatic run_phase(input int n_items, input int sidle, input int rstall);
        t_pixel p;
        t_event none [$];
        int     landed;
        sender_idle_pct    = sidle;
        receiver_stall_pct = rstall;
        landed = 0;
        while (landed < n_items) begin
            p = random_pixel();
            if (in_frame(p)) landed++;
            send_pixel(p, 1'b0, none);
        end
        settle_block();
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Cycle counter and timeout.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Event receiver: stalls at random or for a hold-off, and checks each transaction.
    initial begin
        t_event exp_ev;
        bit     take;
        i_evt_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_cycles > 0) begin
                holdoff_cycles--;
                take = 1'b0;
            end else begin
                take = ($urandom_range(99) >= receiver_stall_pct);
            end
            i_evt_ready <= take;
            #1;
            if (o_evt_valid && take) begin
                if (expected_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected event: x=%0d y=%0d t=%0d pol=%0b",
                                 o_event.event_x, o_event.event_y, o_event.event_time,
                                 o_event.polarity);
                end else begin
                    exp_ev = expected_events.pop_front();
                    if (o_event.event_x !== exp_ev.event_x
                        || o_event.event_y !== exp_ev.event_y
                        || o_event.event_time !== exp_ev.event_time
                        || o_event.polarity !== exp_ev.polarity
                        || o_event.last_of_pixel !== exp_ev.last_of_pixel
                        || o_event.overflow !== exp_ev.overflow) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Event mismatch: expected x=%0d y=%0d t=%0d ",
                                      "pol=%0b last=%0b ovf=%0b, got x=%0d y=%0d ",
                                      "t=%0d pol=%0b last=%0b ovf=%0b"},
                                     exp_ev.event_x, exp_ev.event_y, exp_ev.event_time,
                                     exp_ev.polarity, exp_ev.last_of_pixel, exp_ev.overflow,
                                     o_event.event_x, o_event.event_y, o_event.event_time,
                                     o_event.polarity, o_event.last_of_pixel,
                                     o_event.overflow);
                    end
                end
            end
        end
    end

    // Main sequence: reset, directed rows, then the random phases.
    initial begin
        t_event typed_evs [$];
        t_event ev;
        i_rst_n            = 1'b0;
        i_pix_valid        = 1'b0;
        i_pixel            = '0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CFG_FRAME_WIDTH;
        i_cfg_data         = '0;
        mismatches         = 0;
        holdoff_cycles     = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        width_reg          = 10'd640;
        height_reg         = 9'd480;
        on_thr_reg         = 24'd2560;
        off_thr_reg        = 24'd2560;
        time_now           = 48'd10000;
        cluster_w          = 6;
        cluster_h          = 3;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset settings.
        foreach (directed_rows[r]) begin
            typed_evs.delete();
            for (int k = 0; k < directed_rows[r].n_events; k++) begin
                ev.event_x       = directed_rows[r].pix.pixel_x;
                ev.event_y       = directed_rows[r].pix.pixel_y;
                ev.event_time    = (k == 0) ? directed_rows[r].t0 : directed_rows[r].t1;
                ev.polarity      = directed_rows[r].pol;
                ev.last_of_pixel = (k == directed_rows[r].n_events - 1);
                ev.overflow      = 1'b0;
                typed_evs.insert(typed_evs.size(), ev);
            end
            send_pixel(directed_rows[r].pix, directed_rows[r].typed, typed_evs);
        end
        settle_block();

        // Reset settings, no idling.
        run_phase(58, 0, 0);

        // Zero thresholds act as one: nearly every change hits the event cap.
        write_reg(CFG_ON_THRESH, 24'd0);
        write_reg(CFG_OFF_THRESH, 24'd0);
        run_phase(30, 52, 0);

        // Largest ON threshold never crosses; any fall in pixel value gives OFF events.
        write_reg(CFG_ON_THRESH, 24'hFF_FFFF);
        write_reg(CFG_OFF_THRESH, 24'd256);
        run_phase(58, 0, 52);

        // Single-pixel frame, both sides idling a little.
        write_reg(CFG_FRAME_WIDTH, 24'd1);
        write_reg(CFG_FRAME_HEIGHT, 24'd1);
        write_reg(CFG_ON_THRESH, 24'd256);
        write_reg(CFG_OFF_THRESH, 24'd700);
        cluster_w = 1;
        cluster_h = 1;
        run_phase(58, 9, 9);

        // Full frame near the top of the time range, with a long receiver hold-off.
        write_reg(CFG_FRAME_WIDTH, 24'd640);
        write_reg(CFG_FRAME_HEIGHT, 24'd480);
        write_reg(CFG_ON_THRESH, CFG_W'($urandom_range(1, 4096)));
        write_reg(CFG_OFF_THRESH, CFG_W'($urandom_range(1, 4096)));
        cluster_w      = 6;
        cluster_h      = 3;
        time_now       = TIME_TOP - 48'd200000 - TIME_W'($urandom_range(0, 100000));
        holdoff_cycles = 4000;
        run_phase(58, 0, 0);

        // Zero-sized frame ignores everything.
        write_reg(CFG_FRAME_WIDTH, 24'd0);
        write_reg(CFG_FRAME_HEIGHT, 24'd0);
        typed_evs.delete();
        repeat (10) send_pixel(random_pixel(), 1'b0, typed_evs);
        settle_block();

        // Random frame size; stored entries are reused under the new mapping.
        write_reg(CFG_FRAME_WIDTH, CFG_W'($urandom_range(1, 640)));
        write_reg(CFG_FRAME_HEIGHT, CFG_W'($urandom_range(1, 480)));
        write_reg(CFG_ON_THRESH,
                  CFG_W'($urandom_range(1, 24'hFF_FFFF) >> $urandom_range(0, 14)));
        write_reg(CFG_OFF_THRESH,
                  CFG_W'($urandom_range(1, 24'hFF_FFFF) >> $urandom_range(0, 14)));
        cluster_w = 8;
        cluster_h = 4;
        run_phase(58, 52, 52);

        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
